// File: src/crg_pkg.sv
// ----------------------------------------------------------------------------
// Color ramp gradient map package
// Shared constants, codes and the controller and datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none
package crg_pkg;
  localparam int CHANNEL_BITS = 16;
  localparam int MAX_STOPS_DEF = 8;
  localparam int CNT_BITS = 4;
  localparam int STEP_BITS = 5;
  localparam int DIV_STEPS = 16;
  localparam int BLEND_STEPS = 7;
  localparam int GRAY_STEPS = 4;

  localparam logic [16:0] ONE_Q = 17'h10000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  localparam logic [2:0] REG_STOP_COUNT = 3'd0;
  localparam logic [2:0] REG_START_COLOR = 3'd1;
  localparam logic [2:0] REG_END_COLOR = 3'd2;
  localparam logic [2:0] REG_GRAY_WEIGHTS = 3'd3;
  localparam logic [2:0] REG_INTERP_LINEAR = 3'd4;

  localparam logic [3:0] RST_STOP_COUNT = 4'd1;
  localparam logic [47:0] RST_START_COLOR = 48'h0;
  localparam logic [47:0] RST_END_COLOR = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] RST_GRAY_WEIGHTS = 48'd80264863701617;
  localparam logic RST_INTERP_LINEAR = 1'b1;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic gray_step;
    logic srch_rd;
    logic srch_cmp;
    logic div_init;
    logic div_step;
    logic blend_step;
    logic out_load;
    logic [STEP_BITS-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_pixel;
    logic srch_end;
    logic srch_hit;
    logic fac_trivial;
    logic out_full;
  } sts_t;
endpackage
`default_nettype wire

// File: src/crg_in_if.sv
// ----------------------------------------------------------------------------
// Color ramp input channel
// Carries one load or shade request with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface crg_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [2:0] stop_index;
  logic [15:0] stop_position;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  modport source (output valid, opcode, stop_index, stop_position, red, green, blue,
                  input ready);
  modport sink (input valid, opcode, stop_index, stop_position, red, green, blue,
                output ready);
endinterface
`default_nettype wire

// File: src/crg_out_if.sv
// ----------------------------------------------------------------------------
// Color ramp output channel
// Carries one mapped pixel request with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface crg_out_if;
  logic valid;
  logic ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] gray_level;
  logic [3:0] segment;
  modport source (output valid, out_red, out_green, out_blue, gray_level, segment,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, gray_level, segment,
                output ready);
endinterface
`default_nettype wire

// File: src/color_ramp_gradient_map.sv
// ----------------------------------------------------------------------------
// Color ramp gradient map
// Maps each pixel through its gray level onto a ramp of up to MAX_STOPS stops.
// ----------------------------------------------------------------------------
// A load request writes one stop. A shade request computes the gray level
// on the shared multiplier, reads stops from the stop memory until one lies
// above the gray level or no active stop is left, sets up the blend factor,
// runs the bit-serial divider (skipped when the factor is fixed at zero or
// one), blends on the same multiplier and loads the output register, waiting
// while a result is still held there. One request is in work at a time; the
// next one is accepted in the cycle after the result is loaded, and a
// finished result waits in the output register.
`default_nettype none
module color_ramp_gradient_map #(
  parameter int MAX_STOPS = crg_pkg::MAX_STOPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [47:0] cfg_data,
  crg_in_if.sink in,
  crg_out_if.source out
);
  crg_pkg::cmd_t cmd;
  crg_pkg::sts_t sts;

  crg_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .sts(sts),
    .cmd(cmd)
  );

  crg_datapath #(.MAX_STOPS(MAX_STOPS)) u_datapath (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in(in),
    .out(out),
    .cmd(cmd),
    .sts(sts)
  );
endmodule
`default_nettype wire

// File: src/crg_datapath.sv
// ----------------------------------------------------------------------------
// Color ramp datapath
// Configuration, stop memory, shared multiplier, search, divider and output.
// ----------------------------------------------------------------------------
`default_nettype none
module crg_datapath #(
  parameter int MAX_STOPS = crg_pkg::MAX_STOPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [47:0] cfg_data,
  crg_in_if.sink in,
  crg_out_if.source out,
  input  wire crg_pkg::cmd_t cmd,
  output crg_pkg::sts_t sts
);
  localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

  logic [3:0] stop_count;
  logic [47:0] start_color;
  logic [47:0] end_color;
  logic [47:0] gray_weights;
  logic interp_linear;

  logic [63:0] stops [MAX_STOPS];
  logic [63:0] rd_q;
  logic [15:0] px [3];
  logic [15:0] gray;
  logic [3:0] idx;
  logic [16:0] low_pos;
  logic [47:0] low_col;
  logic [16:0] high_pos;
  logic [47:0] high_col;
  logic [16:0] rem;
  logic [16:0] den;
  logic [16:0] fac;
  logic [32:0] prod;
  logic [33:0] acc;
  logic [15:0] res [3];
  logic out_valid;

  logic [3:0] count_sat;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [33:0] gsum;
  logic [17:0] gshift;
  logic [33:0] bsum;
  logic [17:0] rem2;
  logic [4:0] bp;
  logic [1:0] bj;
  logic [1:0] gk;
  logic [47:0] rd_col;

  assign count_sat = (32'(stop_count) > MAX_STOPS) ? 4'(MAX_STOPS) : stop_count;
  assign rd_col = rd_q[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= crg_pkg::RST_STOP_COUNT;
      start_color <= crg_pkg::RST_START_COLOR;
      end_color <= crg_pkg::RST_END_COLOR;
      gray_weights <= crg_pkg::RST_GRAY_WEIGHTS;
      interp_linear <= crg_pkg::RST_INTERP_LINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crg_pkg::REG_STOP_COUNT: stop_count <= cfg_data[3:0];
        crg_pkg::REG_START_COLOR: start_color <= cfg_data;
        crg_pkg::REG_END_COLOR: end_color <= cfg_data;
        crg_pkg::REG_GRAY_WEIGHTS: gray_weights <= cfg_data;
        crg_pkg::REG_INTERP_LINEAR: interp_linear <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in.opcode == crg_pkg::OP_LOAD && 32'(in.stop_index) < MAX_STOPS) begin
      stops[AW'(in.stop_index)] <= {in.stop_position, in.red, in.green, in.blue};
    end
    if (cmd.srch_rd) begin
      rd_q <= stops[AW'(idx)];
    end
  end

  assign gk = cmd.cnt[1:0];
  assign bj = 2'(cmd.cnt >> 1);
  assign bp = cmd.cnt - 5'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.gray_step) begin
      unique case (gk)
        2'd0: begin mul_a = {1'b0, gray_weights[47:32]}; mul_b = px[0]; end
        2'd1: begin mul_a = {1'b0, gray_weights[31:16]}; mul_b = px[1]; end
        default: begin mul_a = {1'b0, gray_weights[15:0]}; mul_b = px[2]; end
      endcase
    end else begin
      unique case ({bj, cmd.cnt[0]})
        3'b000: begin mul_a = crg_pkg::ONE_Q - fac; mul_b = low_col[47:32]; end
        3'b001: begin mul_a = fac; mul_b = high_col[47:32]; end
        3'b010: begin mul_a = crg_pkg::ONE_Q - fac; mul_b = low_col[31:16]; end
        3'b011: begin mul_a = fac; mul_b = high_col[31:16]; end
        3'b100: begin mul_a = crg_pkg::ONE_Q - fac; mul_b = low_col[15:0]; end
        3'b101: begin mul_a = fac; mul_b = high_col[15:0]; end
        default: ;
      endcase
    end
  end

  assign gsum = acc + {1'b0, prod};
  assign gshift = gsum[33:16];
  assign bsum = acc + {1'b0, prod};
  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px[0] <= in.red;
      px[1] <= in.green;
      px[2] <= in.blue;
      idx <= '0;
      low_pos <= '0;
      low_col <= start_color;
      high_pos <= crg_pkg::ONE_Q;
      high_col <= end_color;
    end
    if (cmd.gray_step || cmd.blend_step) begin
      prod <= mul_a * {1'b0, mul_b};
    end
    if (cmd.gray_step) begin
      unique case (gk)
        2'd1: acc <= {1'b0, prod};
        2'd2: acc <= gsum;
        2'd3: gray <= (gshift > 18'h0FFFF) ? 16'hFFFF : gshift[15:0];
        default: ;
      endcase
    end
    if (cmd.srch_cmp) begin
      if (sts.srch_hit) begin
        high_pos <= {1'b0, rd_q[63:48]};
        high_col <= rd_col;
      end else begin
        low_pos <= {1'b0, rd_q[63:48]};
        low_col <= rd_col;
        idx <= idx + 4'd1;
      end
    end
    if (cmd.div_init) begin
      fac <= (high_pos <= low_pos) ? crg_pkg::ONE_Q : 17'd0;
      rem <= {1'b0, gray} - low_pos;
      den <= high_pos - low_pos;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= 17'(rem2 - {1'b0, den});
        fac <= {fac[15:0], 1'b1};
      end else begin
        rem <= rem2[16:0];
        fac <= {fac[15:0], 1'b0};
      end
    end
    if (cmd.blend_step && cmd.cnt != '0) begin
      if (!bp[0]) begin
        acc <= {1'b0, prod};
      end else begin
        res[2'(bp >> 1)] <= bsum[31:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out.out_red <= interp_linear ? res[0] : gray;
      out.out_green <= interp_linear ? res[1] : gray;
      out.out_blue <= interp_linear ? res[2] : gray;
      out.gray_level <= gray;
      out.segment <= idx;
    end
  end

  assign out.valid = out_valid;
  assign in.ready = cmd.in_ready;

  assign sts.in_valid = in.valid;
  assign sts.in_pixel = (in.opcode == crg_pkg::OP_SHADE);
  assign sts.srch_end = (idx == count_sat);
  assign sts.srch_hit = ({1'b0, gray} < {1'b0, rd_q[63:48]});
  assign sts.fac_trivial = (high_pos <= low_pos) || ({1'b0, gray} <= low_pos);
  assign sts.out_full = out_valid && !out.ready;
endmodule
`default_nettype wire

// File: src/crg_ctrl.sv
// ----------------------------------------------------------------------------
// Color ramp controller
// Sequences gray level, stop search, division, blend and output per request.
// ----------------------------------------------------------------------------
`default_nettype none
module crg_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire crg_pkg::sts_t sts,
  output crg_pkg::cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRAY = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_CMP = 3'd3;
  localparam logic [2:0] S_DIVI = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_BLEND = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [crg_pkg::STEP_BITS-1:0] cnt;
  logic [crg_pkg::STEP_BITS-1:0] cnt_next;

  always_comb begin
    cmd = '0;
    cmd.cnt = cnt;
    state_next = state;
    cnt_next = cnt;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.accept = 1'b1;
          cnt_next = '0;
          if (sts.in_pixel) state_next = S_GRAY;
        end
      end
      S_GRAY: begin
        cmd.gray_step = 1'b1;
        cnt_next = cnt + crg_pkg::STEP_BITS'(1);
        if (cnt == crg_pkg::STEP_BITS'(crg_pkg::GRAY_STEPS - 1)) state_next = S_SRCH;
      end
      S_SRCH: begin
        if (sts.srch_end) begin
          state_next = S_DIVI;
        end else begin
          cmd.srch_rd = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next = sts.srch_hit ? S_DIVI : S_SRCH;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next = '0;
        state_next = sts.fac_trivial ? S_BLEND : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + crg_pkg::STEP_BITS'(1);
        if (cnt == crg_pkg::STEP_BITS'(crg_pkg::DIV_STEPS - 1)) begin
          cnt_next = '0;
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        cmd.blend_step = 1'b1;
        cnt_next = cnt + crg_pkg::STEP_BITS'(1);
        if (cnt == crg_pkg::STEP_BITS'(crg_pkg::BLEND_STEPS - 1)) state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_full) else $error("result loaded over a held result");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == crg_pkg::STEP_BITS'(crg_pkg::DIV_STEPS - 1))
    |=> state == S_BLEND) else $error("division did not end after its last step");
  a_pixel_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.in_pixel) |=> (state == S_GRAY && cnt == '0))
    else $error("accepted pixel did not start the gray level");
`endif
endmodule
`default_nettype wire
